FILE: src/prc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the program run controller.
package prc_pkg;

   localparam int AREA_BYTES_DEFAULT = 64;

   localparam int CFG_SIZE_W  = 7;
   localparam int BYTE_IDX_W  = 6;
   localparam int CW_W        = 16;
   localparam int DELTA_W     = 32;
   localparam int CNT_W       = 32;
   localparam int ACC_W       = 64;
   localparam int MEAN_W      = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Item operation codes
   localparam logic [1:0] OP_CONTROL    = 2'd0;
   localparam logic [1:0] OP_TICK       = 2'd1;
   localparam logic [1:0] OP_BYTE_WRITE = 2'd2;
   localparam logic [1:0] OP_BYTE_READ  = 2'd3;

   // Control word command masks
   localparam logic [CW_W-1:0] CMD_STOP   = 16'h0001;
   localparam logic [CW_W-1:0] CMD_RUN    = 16'h0002;
   localparam logic [CW_W-1:0] CMD_RESET  = 16'h0004;
   localparam logic [CW_W-1:0] CMD_HALT   = 16'h0008;
   localparam logic [CW_W-1:0] CMD_RESUME = 16'h0010;

   // Area select codes
   localparam logic AREA_INPUT  = 1'b0;
   localparam logic AREA_OUTPUT = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] REG_PROGRAM_LOADED = 2'd0;
   localparam logic [1:0] REG_INPUT_AREA     = 2'd1;
   localparam logic [1:0] REG_OUTPUT_AREA    = 2'd2;

   localparam logic [CFG_SIZE_W-1:0] AREA_SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      RUN_STOPPED = 2'd0,
      RUN_RUNNING = 2'd1,
      RUN_HALTED  = 2'd2
   } run_state_type;

   typedef enum logic [2:0] {
      CTL_IDLE   = 3'd0,
      CTL_EXEC   = 3'd1,
      CTL_LAUNCH = 3'd2,
      CTL_WAIT   = 3'd3,
      CTL_FINISH = 3'd4
   } ctl_state_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [CW_W-1:0]       control_word;
      logic [DELTA_W-1:0]    delta_ns;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic [7:0]            byte_value;
      logic                  area_select;
   } req_item_type;

   typedef struct packed {
      logic [3:0]        status_word;
      logic [1:0]        program_state;
      logic [CNT_W-1:0]  cycle_total;
      logic [MEAN_W-1:0] mean_cycle_time;
      logic [7:0]        read_byte;
      logic              access_fault;
   } rsp_item_type;

   typedef struct packed {
      logic                  program_loaded;
      logic [CFG_SIZE_W-1:0] input_area_bytes;
      logic [CFG_SIZE_W-1:0] output_area_bytes;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_item;
      logic execute;
      logic div_start;
      logic copy_step;
      logic load_result;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] operation;
      logic       copy_done;
      logic       div_done;
   } dp_status_type;

endpackage

FILE: src/prc_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, keeps the low quotient word.
module prc_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [prc_pkg::ACC_W-1:0]  dividend,
   input  logic [prc_pkg::CNT_W-1:0]  divisor,
   output logic                       busy,
   output logic [prc_pkg::MEAN_W-1:0] quotient
);
   import prc_pkg::*;

   localparam int STEP_W = $clog2(ACC_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;
   logic [ACC_W-1:0]  dvd_ff, dvd_in;
   logic [MEAN_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;

   logic [CNT_W:0] shifted;
   logic [CNT_W:0] diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[ACC_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = (shifted >= {1'b0, dsr_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         dsr_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
         step_in = STEP_W'(ACC_W);
         // zero cycles gives a zero mean
         busy_in = (divisor != '0);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         dvd_in  = {dvd_ff[ACC_W-2:0], 1'b0};
         quo_in  = {quo_ff[MEAN_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         quo_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         quo_ff  <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      step_ff <= step_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/prc_datapath.sv
`timescale 1ns / 1ps
// Datapath: run state, counters, byte areas, area copy and mean divider.
module prc_datapath #(
   parameter int AREA_BYTES = prc_pkg::AREA_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  prc_pkg::cfg_type       cfg,
   input  prc_pkg::req_item_type  req_item,
   input  prc_pkg::ctl_cmd_type   cmd,
   output prc_pkg::dp_status_type sts,
   output prc_pkg::rsp_item_type  result
);
   import prc_pkg::*;

   localparam int EFF_W  = $clog2(AREA_BYTES + 1);
   localparam int ADDR_W = (AREA_BYTES > 1) ? $clog2(AREA_BYTES) : 1;
   localparam int CMP_W  = (EFF_W > CFG_SIZE_W) ? EFF_W : CFG_SIZE_W;
   localparam logic [CMP_W-1:0] AREA_LIMIT = CMP_W'(AREA_BYTES);

   function automatic logic [EFF_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] size);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(size);
      return (ext > AREA_LIMIT) ? AREA_LIMIT[EFF_W-1:0] : ext[EFF_W-1:0];
   endfunction

   req_item_type     item_ff;
   run_state_type    run_state_ff, run_state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             fault_ff, fault_in;
   logic             clear_areas;

   logic [7:0] in_mem  [AREA_BYTES];
   logic [7:0] out_mem [AREA_BYTES];
   logic [AREA_BYTES-1:0] in_valid_ff;
   logic [AREA_BYTES-1:0] out_valid_ff;
   logic [7:0] in_rd_ff, out_rd_ff;
   logic       in_rd_valid_ff, out_rd_valid_ff;

   logic [EFF_W-1:0]  copy_idx_ff, copy_idx_in;
   logic [EFF_W-1:0]  copy_n_ff, copy_n_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_waddr_ff;
   logic              copy_rd_go;
   logic [ADDR_W-1:0] copy_addr;

   logic [EFF_W-1:0]  eff_in, eff_out, copy_len;
   logic [CMP_W-1:0]  idx_ext;
   logic [ADDR_W-1:0] item_addr;
   logic              in_range_in, in_range_out;
   logic              in_wr_en, in_rd_en, out_wr_en, out_rd_en;
   logic [ADDR_W-1:0] in_rd_addr;
   logic              is_read;
   logic [7:0]        rd_sel;
   logic              div_busy;
   logic [MEAN_W-1:0] div_quotient;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_ff <= req_item;
      end
   end

   always_comb begin
      eff_in       = eff_size(cfg.input_area_bytes);
      eff_out      = eff_size(cfg.output_area_bytes);
      copy_len     = (eff_in < eff_out) ? eff_in : eff_out;
      idx_ext      = CMP_W'(item_ff.byte_index);
      item_addr    = idx_ext[ADDR_W-1:0];
      in_range_in  = idx_ext < CMP_W'(eff_in);
      in_range_out = idx_ext < CMP_W'(eff_out);
      is_read      = (item_ff.operation == OP_BYTE_READ);
   end

   // Command decode and counter updates
   always_comb begin
      run_state_in = run_state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      clear_areas  = 1'b0;
      copy_n_in    = copy_n_ff;
      fault_in     = fault_ff;
      if (cmd.execute) begin
         copy_n_in = '0;
         fault_in  = 1'b0;
         case (item_ff.operation)
            OP_CONTROL: begin
               if (|(item_ff.control_word & CMD_STOP)) begin
                  run_state_in = RUN_STOPPED;
               end else if (|(item_ff.control_word & CMD_RUN)) begin
                  if (run_state_ff == RUN_STOPPED) begin
                     cnt_in       = '0;
                     acc_in       = '0;
                     run_state_in = RUN_RUNNING;
                  end else if (run_state_ff == RUN_HALTED) begin
                     run_state_in = RUN_RUNNING;
                  end
               end else if (|(item_ff.control_word & CMD_RESET)) begin
                  run_state_in = RUN_STOPPED;
                  cnt_in       = '0;
                  acc_in       = '0;
                  clear_areas  = 1'b1;
               end else if (|(item_ff.control_word & CMD_HALT)) begin
                  if (run_state_ff == RUN_RUNNING) begin
                     run_state_in = RUN_HALTED;
                  end
               end else if (|(item_ff.control_word & CMD_RESUME)) begin
                  if (run_state_ff == RUN_HALTED) begin
                     run_state_in = RUN_RUNNING;
                  end
               end
            end
            OP_TICK: begin
               acc_in = acc_ff + ACC_W'(item_ff.delta_ns);
               if (run_state_ff == RUN_RUNNING) begin
                  cnt_in    = cnt_ff + CNT_W'(1);
                  copy_n_in = copy_len;
               end
            end
            OP_BYTE_WRITE: begin
               fault_in = !in_range_in;
            end
            OP_BYTE_READ: begin
               fault_in = (item_ff.area_select == AREA_OUTPUT) ? !in_range_out : !in_range_in;
            end
            default: begin
               fault_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_state_ff <= RUN_STOPPED;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         copy_n_ff    <= '0;
         copy_idx_ff  <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         run_state_ff <= run_state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         copy_n_ff    <= copy_n_in;
         copy_idx_ff  <= copy_idx_in;
         copy_pend_ff <= copy_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      fault_ff <= fault_in;
   end

   // Area copy: read one input byte a cycle, write it to the output area in the next cycle
   always_comb begin
      copy_rd_go   = cmd.copy_step && (copy_idx_ff != copy_n_ff);
      copy_addr    = copy_idx_ff[ADDR_W-1:0];
      copy_idx_in  = copy_idx_ff;
      copy_pend_in = copy_pend_ff;
      if (cmd.execute) begin
         copy_idx_in  = '0;
         copy_pend_in = 1'b0;
      end else if (cmd.copy_step) begin
         copy_pend_in = copy_rd_go;
         if (copy_rd_go) begin
            copy_idx_in = copy_idx_ff + EFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (copy_rd_go) begin
         copy_waddr_ff <= copy_addr;
      end
   end

   always_comb begin
      in_wr_en   = cmd.execute && (item_ff.operation == OP_BYTE_WRITE) && in_range_in;
      in_rd_en   = (cmd.execute && is_read && (item_ff.area_select == AREA_INPUT))
                   || copy_rd_go;
      in_rd_addr = cmd.copy_step ? copy_addr : item_addr;
      out_wr_en  = cmd.copy_step && copy_pend_ff;
      out_rd_en  = cmd.execute && is_read && (item_ff.area_select == AREA_OUTPUT);
   end

   always_ff @(posedge clock) begin
      if (in_wr_en) begin
         in_mem[item_addr] <= item_ff.byte_value;
      end
      if (in_rd_en) begin
         in_rd_ff       <= in_mem[in_rd_addr];
         in_rd_valid_ff <= in_valid_ff[in_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (out_wr_en) begin
         out_mem[copy_waddr_ff] <= in_rd_ff;
      end
      if (out_rd_en) begin
         out_rd_ff       <= out_mem[item_addr];
         out_rd_valid_ff <= out_valid_ff[item_addr];
      end
   end

   // Entry valid bits: an entry not yet written since reset or a reset command reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= '0;
         out_valid_ff <= '0;
      end else if (clear_areas) begin
         in_valid_ff  <= '0;
         out_valid_ff <= '0;
      end else begin
         if (in_wr_en) begin
            in_valid_ff[item_addr] <= 1'b1;
         end
         if (out_wr_en) begin
            out_valid_ff[copy_waddr_ff] <= in_rd_valid_ff;
         end
      end
   end

   prc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      if (item_ff.area_select == AREA_OUTPUT) begin
         rd_sel = out_rd_valid_ff ? out_rd_ff : 8'd0;
      end else begin
         rd_sel = in_rd_valid_ff ? in_rd_ff : 8'd0;
      end
   end

   always_comb begin
      sts.operation = item_ff.operation;
      sts.copy_done = (copy_idx_ff == copy_n_ff) && !copy_pend_ff;
      sts.div_done  = !div_busy;

      result.status_word     = {run_state_ff == RUN_HALTED, run_state_ff == RUN_RUNNING,
                                cfg.program_loaded, cfg.program_loaded};
      result.program_state   = run_state_ff;
      result.cycle_total     = cnt_ff;
      result.mean_cycle_time = div_quotient;
      result.read_byte       = (is_read && !fault_ff) ? rd_sel : 8'd0;
      result.access_fault    = fault_ff;
   end

endmodule

FILE: src/prc_controller.sv
`timescale 1ns / 1ps
// Sequencer: steps one item through execute, copy/divide (control and tick items) and result load.
module prc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   input  prc_pkg::dp_status_type sts,
   output prc_pkg::ctl_cmd_type   cmd,
   output logic                   req_stall
);
   import prc_pkg::*;

   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if ((sts.operation == OP_CONTROL) || (sts.operation == OP_TICK)) begin
               state_in = CTL_LAUNCH;
            end else begin
               state_in = CTL_FINISH;
            end
         end
         CTL_LAUNCH: begin
            state_in = CTL_WAIT;
         end
         CTL_WAIT: begin
            if (sts.copy_done && sts.div_done) begin
               state_in = CTL_FINISH;
            end
         end
         CTL_FINISH: begin
            if (out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTL_IDLE: begin
            req_stall      = 1'b0;
            cmd.latch_item = req_valid;
         end
         CTL_EXEC: begin
            cmd.execute = 1'b1;
         end
         CTL_LAUNCH: begin
            cmd.div_start = 1'b1;
            cmd.copy_step = 1'b1;
         end
         CTL_WAIT: begin
            cmd.copy_step = 1'b1;
         end
         CTL_FINISH: begin
            cmd.load_result = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/plc_program_run_controller.sv
`timescale 1ns / 1ps
// Top level of the program run controller: channels, config registers, result register.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_item) carries one item per operation:
//    control word write, time tick, input byte write or byte read. An item is taken
//    at an edge with req_valid high and req_stall low.
//  - Result channel (rsp_valid / rsp_stall / rsp_item) returns exactly one item per
//    request: status word, run state, cycle count, mean cycle time, read byte, fault.
//  - Configuration port (APB style, pready tied high) holds program_loaded at 0x0,
//    input_area_bytes at 0x4 and output_area_bytes at 0x8; write only while idle.
//  - A byte write or read goes from execute straight to result load. A tick or
//    control write runs the 64-step mean divider alongside the area copy (one
//    byte a cycle); a tick while running copies min(input, output) bytes, each size
//    capped at AREA_BYTES, and other items copy none. With a zero cycle count the
//    divider does not run; the result is loaded once copy and divider are done.
//  - One item is worked on at a time; req_stall rises the cycle after acceptance and
//    drops once the result sits in the output register.
//  - A stalled result holds in the output register; the next item is still taken and
//    worked on, and its result waits until the register frees up.
//  - Reset (synchronous): stopped, counters zero, both byte areas read as zero, area
//    sizes 64, no program loaded. No clearing pass; the block is ready at once.
module plc_program_run_controller #(
   parameter int AREA_BYTES = prc_pkg::AREA_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  prc_pkg::req_item_type          req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output prc_pkg::rsp_item_type          rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [prc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [prc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [prc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import prc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic [1:0]    csr_index;
   logic          csr_write;

   ctl_cmd_type   cmd;
   dp_status_type sts;
   rsp_item_type  result;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff;
   logic          out_free;

   // Configuration registers: write on the access phase, word addressed
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PROGRAM_LOADED: cfg_in.program_loaded    = pwdata[0];
            REG_INPUT_AREA:     cfg_in.input_area_bytes  = pwdata[CFG_SIZE_W-1:0];
            REG_OUTPUT_AREA:    cfg_in.output_area_bytes = pwdata[CFG_SIZE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.program_loaded    <= 1'b0;
         cfg_ff.input_area_bytes  <= AREA_SIZE_RESET;
         cfg_ff.output_area_bytes <= AREA_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back; unmapped addresses read zero
   always_comb begin
      case (csr_index)
         REG_PROGRAM_LOADED: prdata = CSR_DATA_W'(cfg_ff.program_loaded);
         REG_INPUT_AREA:     prdata = CSR_DATA_W'(cfg_ff.input_area_bytes);
         REG_OUTPUT_AREA:    prdata = CSR_DATA_W'(cfg_ff.output_area_bytes);
         default:            prdata = '0;
      endcase
   end

   prc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   prc_datapath #(
      .AREA_BYTES (AREA_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .result   (result)
   );

   // Output register: load when empty or being drained, hold while stalled
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // An accepted item blocks the next one until its result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted back to back");

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   // No copy or divide left running once ready for the next item
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (sts.copy_done && sts.div_done))
      else $error("background work still running while idle");

endmodule
